### design/token_bucket_rate_limiter_core_macros.svh
// assertion macros of the rate limiter rtl
`ifndef TOKEN_BUCKET_RATE_LIMITER_CORE_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_CORE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define TBRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tbrl implication check failed");

// next-cycle implication, checked while out of reset
`define TBRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tbrl next-cycle check failed");

`endif

### design/tbrl_pkg.sv
// types and constants of the token bucket rate limiter
`default_nettype none
package tbrl_pkg;

	localparam int IDX_IN_W = 10;
	localparam int TS_W     = 48;
	localparam int RETRY_W  = 17;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 1'b1;

	localparam logic [CFG_W-1:0]   MAX_TOKENS_RST = 16'd100;
	localparam logic [CFG_W-1:0]   WINDOW_RST     = 16'd60;
	localparam logic [RETRY_W-1:0] RETRY_SAT      = 17'h1FFFF;

	typedef struct packed {
		logic [IDX_IN_W-1:0] bucket_index;
		logic [TS_W-1:0]     timestamp;
	} req_t;

	typedef struct packed {
		logic               allowed;
		logic [RETRY_W-1:0] retry_after_seconds;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_IDX,
		ST_IDX2,
		ST_READ,
		ST_EVAL,
		ST_UPD,
		ST_DEC,
		ST_DIV
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_en;
		logic capture;
		logic idx1;
		logic idx2;
		logic rd_en;
		logic eval;
		logic upd;
		logic dec;
		logic res_fast;
		logic div_start;
		logic res_div;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic grant;
		logic div_zero;
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

### design/token_bucket_rate_limiter_core.sv
// top level of the token bucket rate limiter
//
//  channel   | ports                             | beat taken when
//  ----------+-----------------------------------+-----------------------------
//  request   | start, busy, req                  | start && !busy at clk rise
//  result    | done, rsp                         | every cycle done is high
//  config    | cfg_we, cfg_index, cfg_wdata      | cfg_we at clk rise
//
// a granted request steps through IDX, IDX2, READ, EVAL, UPD and DEC before its
// result shows, and the next beat can be taken in the same cycle as that result
// a denial with nonzero max tokens runs the restoring divider, one quotient bit
// a cycle over SW = clog2(65535 * TICKS_PER_SECOND + 1) bits
// after reset a clearing pass over every entry of the valid table holds busy
// high; config writes are taken during it
// the result is a one-cycle strobe and cannot be stalled by the receiver
`default_nettype none
module token_bucket_rate_limiter_core #(
	parameter int NUM_BUCKETS      = 1024,
	parameter int TICKS_PER_SECOND = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire tbrl_pkg::req_t                 req,
	output logic                                done,
	output tbrl_pkg::rsp_t                      rsp,
	input  wire logic                           cfg_we,
	input  wire logic [tbrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tbrl_pkg::CFG_W-1:0]     cfg_wdata
);
	import tbrl_pkg::*;
	`include "token_bucket_rate_limiter_core_macros.svh"

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: clearing pass, per-request steps, divider wait
	tbrl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	// datapath: config registers, bucket tables, refill math, divider
	tbrl_datapath #(
		.NUM_BUCKETS     (NUM_BUCKETS),
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.rsp      (rsp)
	);

	// a result beat always ends a request that held busy
	`TBRL_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy))
	// no two result beats back to back
	`TBRL_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)
	// a grant never carries a wait time
	`TBRL_ASSERT_IMP(a_grant_no_retry, clk, arst_n, done && rsp.allowed, rsp.retry_after_seconds == '0)
	// a denial always asks for at least one second
	`TBRL_ASSERT_IMP(a_deny_retry, clk, arst_n, done && !rsp.allowed, rsp.retry_after_seconds != '0)
endmodule
`default_nettype wire

### design/tbrl_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module tbrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### design/tbrl_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module tbrl_div #(
	parameter int W = 26
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic      [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

### design/tbrl_ctrl.sv
// sequencing state machine of the rate limiter
`default_nettype none
module tbrl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire tbrl_pkg::sts_t sts,
	output tbrl_pkg::cmd_t      cmd,
	output logic                busy
);
	import tbrl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_IDX;
			ST_IDX:   state_d = ST_IDX2;
			ST_IDX2:  state_d = ST_READ;
			ST_READ:  state_d = ST_EVAL;
			ST_EVAL:  state_d = ST_UPD;
			ST_UPD:   state_d = ST_DEC;
			ST_DEC: begin
				if (sts.grant || sts.div_zero) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV:   if (sts.div_done) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clr_en = 1'b1;
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			ST_IDX:   cmd.idx1 = 1'b1;
			ST_IDX2:  cmd.idx2 = 1'b1;
			ST_READ:  cmd.rd_en = 1'b1;
			ST_EVAL:  cmd.eval = 1'b1;
			ST_UPD:   cmd.upd = 1'b1;
			ST_DEC: begin
				cmd.dec       = 1'b1;
				cmd.res_fast  = sts.grant || sts.div_zero;
				cmd.div_start = !(sts.grant || sts.div_zero);
			end
			ST_DIV:   cmd.res_div = sts.div_done;
			default:  cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

### design/tbrl_datapath.sv
// bucket tables, refill arithmetic and result register
`default_nettype none
module tbrl_datapath #(
	parameter int NUM_BUCKETS      = 1024,
	parameter int TICKS_PER_SECOND = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tbrl_pkg::cmd_t                    cmd,
	output tbrl_pkg::sts_t                         sts,
	input  wire tbrl_pkg::req_t                    req,
	input  wire logic                              cfg_we,
	input  wire logic [tbrl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tbrl_pkg::CFG_W-1:0]        cfg_wdata,
	output logic                                   done,
	output tbrl_pkg::rsp_t                         rsp
);
	import tbrl_pkg::*;

	localparam longint unsigned TPS = longint'(TICKS_PER_SECOND);
	localparam int IW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int TPSW = $clog2(TPS + 1);
	localparam int SW   = $clog2(64'd65535 * TPS + 64'd1);
	localparam int LW   = $clog2(64'd65535 * 64'd65535 * TPS + 64'd1);
	localparam int RFW  = SW + 16;
	localparam int SUMW = RFW + 1;
	localparam int DW   = LW + TS_W;
	localparam int PW   = 16 + TPSW;
	localparam bit REDUCE = NUM_BUCKETS < 1024;
	localparam int unsigned RECIP = REDUCE ? (32'd1 << 20) / NUM_BUCKETS : 0;
	localparam logic [TPSW-1:0] TPS_V = TPSW'(TICKS_PER_SECOND);

	logic [CFG_W-1:0] max_q;
	logic [CFG_W-1:0] win_q;
	logic [IW-1:0]    clr_cnt_q;
	req_t             req_q;
	logic [9:0]       quo_idx_q;
	logic [IW-1:0]    idx_q;
	logic [SW-1:0]    scale_q;
	logic [SW-1:0]    divisor_q;
	logic [LW-1:0]    cap_q;
	logic [LW-1:0]    init_q;
	logic             vld_q;
	logic             el_ge_q;
	logic [RFW-1:0]   refill_q;
	logic [LW-1:0]    lvl_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic [30:0]      idx_prod;
	logic [16:0]      idx_rem;
	logic [16:0]      idx_fix;
	logic [IW-1:0]    idx_d;
	logic [PW-1:0]    scale_full;
	logic [PW-1:0]    dvs_full;
	logic [CFG_W-1:0] max_m1;
	logic [TS_W-1:0]  elapsed;
	logic [SUMW-1:0]  lvl_sum;
	logic [LW-1:0]    lvl_upd;
	logic             lvl_ge;
	logic [LW-1:0]    lvl_wr;
	logic [SW-1:0]    deficit;
	logic             div_done;
	logic [SW-1:0]    div_quo;
	logic             vram_we;
	logic [IW-1:0]    vram_waddr;
	logic             vram_rdata;
	logic [DW-1:0]    dram_rdata;
	logic [LW-1:0]    rd_level;
	logic [TS_W-1:0]  rd_time;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_TOKENS_RST;
			win_q <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_TOKENS: max_q <= cfg_wdata;
				CFG_WINDOW:     win_q <= cfg_wdata;
				default:        max_q <= max_q;
			endcase
		end
	end

	// sweep of the valid table after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + IW'(1);
		end
	end

	// index modulo table size via reciprocal and one correction
	assign idx_prod = 31'(req_q.bucket_index) * 31'(RECIP);
	assign idx_rem  = 17'(req_q.bucket_index) - 17'(quo_idx_q) * 17'(NUM_BUCKETS);
	assign idx_fix  = (idx_rem >= 17'(NUM_BUCKETS)) ? idx_rem - 17'(NUM_BUCKETS) : idx_rem;
	assign idx_d    = REDUCE ? IW'(idx_fix) : IW'(req_q.bucket_index);

	assign scale_full = PW'(win_q) * PW'(TPS_V);
	assign dvs_full   = PW'(max_q) * PW'(TPS_V);
	assign max_m1     = (max_q != '0) ? max_q - CFG_W'(1) : '0;

	assign rd_level = dram_rdata[DW-1:TS_W];
	assign rd_time  = dram_rdata[TS_W-1:0];
	assign elapsed  = req_q.timestamp - rd_time;

	assign lvl_sum = SUMW'(rd_level) + SUMW'(refill_q);
	always_comb begin
		if (el_ge_q || lvl_sum > SUMW'(cap_q)) begin
			lvl_upd = cap_q;
		end else begin
			lvl_upd = LW'(lvl_sum);
		end
	end

	assign lvl_ge  = lvl_q >= LW'(scale_q);
	assign deficit = scale_q - SW'(lvl_q);
	always_comb begin
		if (!vld_q) begin
			lvl_wr = init_q;
		end else if (lvl_ge) begin
			lvl_wr = lvl_q - LW'(scale_q);
		end else begin
			lvl_wr = lvl_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.idx1) begin
			quo_idx_q <= idx_prod[29:20];
			scale_q   <= SW'(scale_full);
			divisor_q <= SW'(dvs_full);
		end
		if (cmd.idx2) begin
			idx_q  <= idx_d;
			cap_q  <= LW'(RFW'(max_q) * RFW'(scale_q));
			init_q <= LW'(RFW'(max_m1) * RFW'(scale_q));
		end
		if (cmd.eval) begin
			vld_q    <= vram_rdata;
			el_ge_q  <= elapsed >= TS_W'(scale_q);
			refill_q <= RFW'(elapsed[SW-1:0]) * RFW'(max_q);
		end
		if (cmd.upd) begin
			lvl_q <= lvl_upd;
		end
		if (cmd.res_fast) begin
			rsp_q.allowed             <= lvl_ge || !vld_q;
			rsp_q.retry_after_seconds <= (lvl_ge || !vld_q) ? '0 : RETRY_SAT;
		end else if (cmd.res_div) begin
			rsp_q.allowed             <= 1'b0;
			rsp_q.retry_after_seconds <= RETRY_W'(div_quo[15:0]) + RETRY_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_fast || cmd.res_div;
		end
	end

	assign vram_we    = cmd.clr_en || cmd.dec;
	assign vram_waddr = cmd.clr_en ? clr_cnt_q : idx_q;

	tbrl_ram #(
		.WIDTH(1),
		.DEPTH(NUM_BUCKETS)
	) u_valid_ram (
		.clk  (clk),
		.we   (vram_we),
		.waddr(vram_waddr),
		.wdata(cmd.dec),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(vram_rdata)
	);

	tbrl_ram #(
		.WIDTH(DW),
		.DEPTH(NUM_BUCKETS)
	) u_bucket_ram (
		.clk  (clk),
		.we   (cmd.dec),
		.waddr(idx_q),
		.wdata({lvl_wr, req_q.timestamp}),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(dram_rdata)
	);

	tbrl_div #(
		.W(SW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(deficit),
		.divisor (divisor_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign sts.clr_last = clr_cnt_q == IW'(NUM_BUCKETS - 1);
	assign sts.grant    = !vld_q || lvl_ge;
	assign sts.div_zero = divisor_q == '0;
	assign sts.div_done = div_done;

	assign done = done_q;
	assign rsp  = rsp_q;
endmodule
`default_nettype wire

### dv/token_bucket_rate_limiter_core_test.sv
// self-checking testbench of the token bucket rate limiter core
`timescale 1ns / 1ps
`default_nettype none
module token_bucket_rate_limiter_core_test;
	import tbrl_pkg::*;

	localparam int unsigned NUM_BKT       = 1024;
	localparam int unsigned TICKS_PER_SEC = 1024;
	// slowest run is about 520 beats, each at most one denial plus a random idle
	// gap, plus the clearing pass after reset; this leaves a wide margin over that
	localparam int unsigned CYCLE_LIMIT   = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	req_t                 req;
	logic                 done;
	rsp_t                 rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	token_bucket_rate_limiter_core #(
		.NUM_BUCKETS      (NUM_BKT),
		.TICKS_PER_SECOND (TICKS_PER_SEC)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the bucket table and the two limit registers
	bit              bucket_seen [NUM_BKT];
	bit [63:0]       bucket_level[NUM_BKT];
	bit [TS_W-1:0]   bucket_stamp[NUM_BKT];
	bit [CFG_W-1:0]  cap_tokens;
	bit [CFG_W-1:0]  window_secs;

	// decisions owed by the block, oldest first
	rsp_t            owed_decisions[$];
	int unsigned     mismatch_count;
	int unsigned     cycle_count;
	bit              no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("token_bucket_rate_limiter_core_test failed");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// one request against the shadow table: refill by elapsed ticks, clamp to
	// capacity, then spend one token or work out the wait in whole seconds
	function automatic rsp_t bucket_decide(input req_t r);
		bit [9:0]      b;
		bit [TS_W-1:0] elapsed;
		bit [63:0]     scale;
		bit [63:0]     full;
		bit [63:0]     lvl;
		bit [63:0]     divisor;
		bit [63:0]     secs;
		rsp_t          o;
		b = r.bucket_index;
		scale = 64'(window_secs) * TICKS_PER_SEC;
		full = 64'(cap_tokens) * scale;
		o.allowed = 1'b1;
		o.retry_after_seconds = '0;
		// first use of a bucket: filled to one below capacity, never negative
		if (!bucket_seen[b]) begin
			bucket_seen[b] = 1'b1;
			bucket_level[b] = (cap_tokens != 0) ? (64'(cap_tokens) - 1) * scale : 64'd0;
			bucket_stamp[b] = r.timestamp;
			return o;
		end
		// elapsed ticks wrap with the timestamp width
		elapsed = r.timestamp - bucket_stamp[b];
		if (64'(elapsed) >= scale) begin
			lvl = full;
		end else begin
			// stored level may exceed a capacity lowered since, so clamp anyway
			lvl = bucket_level[b] + 64'(elapsed) * cap_tokens;
			if (lvl > full)
				lvl = full;
		end
		bucket_stamp[b] = r.timestamp;
		// zero window makes a token free, so this always grants
		if (lvl >= scale) begin
			bucket_level[b] = lvl - scale;
			return o;
		end
		bucket_level[b] = lvl;
		o.allowed = 1'b0;
		divisor = 64'(TICKS_PER_SEC) * cap_tokens;
		if (divisor == 0) begin
			// zero capacity never refills: wait saturates
			o.retry_after_seconds = RETRY_SAT;
		end else begin
			secs = (scale - lvl) / divisor + 1;
			o.retry_after_seconds = (secs > 64'(RETRY_SAT)) ? RETRY_SAT : secs[RETRY_W-1:0];
		end
		return o;
	endfunction

	// result side: every strobed beat is matched against the oldest owed decision
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (owed_decisions.size() == 0) begin
				flag_mismatch("result beat with no request outstanding");
			end else begin
				want = owed_decisions.pop_front();
				if (rsp.allowed !== want.allowed)
					flag_mismatch($sformatf("allowed got %b want %b",
						rsp.allowed, want.allowed));
				if (rsp.retry_after_seconds !== want.retry_after_seconds)
					flag_mismatch($sformatf("retry_after_seconds got %0d want %0d",
						rsp.retry_after_seconds, want.retry_after_seconds));
			end
		end
	end

	// request side: idle a random number of cycles, present the beat and hold it
	// until taken; start stays high after the beat so back-to-back beats need no
	// drop, and a later caller lowers it when a gap follows
	task automatic send_req(input bit [9:0] idx, input bit [TS_W-1:0] stamp);
		int unsigned gap;
		req_t item;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		item.bucket_index = idx;
		item.timestamp = stamp;
		if (gap != 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		req = item;
		do @(posedge clk); while (busy !== 1'b0);
		owed_decisions.insert(owed_decisions.size(), bucket_decide(item));
	endtask

	// lower start and let every owed result come back
	task automatic wait_quiet();
		@(negedge clk);
		start = 1'b0;
		while (owed_decisions.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// limit registers are only touched with the block idle
	task automatic set_limits(input bit [CFG_W-1:0] tokens, input bit [CFG_W-1:0] secs);
		wait_quiet();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_MAX_TOKENS;
		cfg_wdata = tokens;
		@(negedge clk);
		cfg_index = CFG_WINDOW;
		cfg_wdata = secs;
		@(negedge clk);
		cfg_we = 1'b0;
		cap_tokens = tokens;
		window_secs = secs;
	endtask

	function automatic bit [TS_W-1:0] rand_stamp();
		return TS_W'({$urandom, $urandom});
	endfunction

	// first use of both table ends and of both timestamp extremes
	task automatic test_first_use();
		send_req(10'd0, 48'd0);
		send_req(10'd1023, 48'hFFFF_FFFF_FFFF);
		// refill of 614 ticks lands just below capacity
		send_req(10'd0, 48'd614);
	endtask

	// one token per second: drain, deny, partial refill, full refill
	task automatic test_refill_and_deny();
		set_limits(16'd1, 16'd1);
		send_req(10'd5, 48'd1000);
		send_req(10'd5, 48'd1000);
		send_req(10'd5, 48'd1512);
		send_req(10'd5, 48'd2536);
		send_req(10'd5, 48'd2536);
	endtask

	// elapsed time taken across the timestamp wrap, then a huge elapsed
	task automatic test_timestamp_wrap();
		send_req(10'd6, 48'hFFFF_FFFF_FFF6);
		send_req(10'd6, 48'd5);
		send_req(10'd6, 48'hFFFF_FFFF_FFFF);
	endtask

	// zero capacity: first use gives zero tokens, then a saturated wait
	task automatic test_zero_capacity();
		set_limits(16'd0, 16'd1);
		send_req(10'd7, 48'd100);
		send_req(10'd7, 48'd100000);
	endtask

	// zero window: tokens cost nothing, everything passes
	task automatic test_zero_window();
		set_limits(16'd4, 16'd0);
		send_req(10'd7, 48'd100001);
		send_req(10'd7, 48'd100001);
		send_req(10'd8, 48'd0);
		send_req(10'd8, 48'd1);
	endtask

	// largest registers over levels stored at another scale, then the longest wait
	task automatic test_extremes();
		set_limits(16'hFFFF, 16'hFFFF);
		send_req(10'd5, 48'd3000);
		set_limits(16'd1, 16'hFFFF);
		send_req(10'd9, 48'd0);
		send_req(10'd9, 48'd1);
	endtask

	// random beats on a few hot buckets with time stepping near the token
	// interval, mixed with fresh buckets, random stamps and backward steps
	task automatic test_random_phase(input bit [CFG_W-1:0] tokens,
		input bit [CFG_W-1:0] secs, input int unsigned count);
		bit [9:0]      hot[3];
		bit [TS_W-1:0] now;
		bit [63:0]     interval;
		bit [9:0]      idx;
		int unsigned   pick;
		set_limits(tokens, secs);
		foreach (hot[i]) hot[i] = 10'($urandom_range(0, NUM_BKT - 1));
		now = rand_stamp();
		interval = (64'(secs) * TICKS_PER_SEC) / ((tokens != 0) ? tokens : 1);
		for (int unsigned n = 0; n < count; n++) begin
			// some stretches run with no idle cycles at all
			if (n % 16 == 0)
				no_idle = ($urandom_range(0, 9) < 3);
			pick = $urandom_range(0, 99);
			idx = (pick < 85) ? hot[$urandom_range(0, 2)] : 10'($urandom_range(0, NUM_BKT - 1));
			pick = $urandom_range(0, 99);
			if (pick < 90)
				now = now + $urandom_range(0, 32'(2 * interval + 1));
			else if (pick < 95)
				now = rand_stamp();
			else
				now = now - $urandom_range(1, 5000);
			send_req(idx, now);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		test_random_phase(MAX_TOKENS_RST, WINDOW_RST, 55);
		test_random_phase(16'd3, 16'd1, 55);
		test_random_phase(16'd1, 16'd1, 55);
		test_random_phase(16'd2, 16'd3, 55);
		test_random_phase(16'hFFFF, 16'hFFFF, 55);
		test_random_phase(16'd1, 16'hFFFF, 55);
		test_random_phase(16'hFFFF, 16'd1, 55);
		test_random_phase(16'd0, 16'd5, 55);
		test_random_phase(16'd7, 16'd0, 55);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_TOKENS;
		cfg_wdata = '0;
		cap_tokens = MAX_TOKENS_RST;
		window_secs = WINDOW_RST;
		mismatch_count = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// the clearing pass after reset shows as busy, which send_req waits out
		test_first_use();
		test_refill_and_deny();
		test_timestamp_wrap();
		test_zero_capacity();
		test_zero_window();
		test_extremes();
		test_random();

		// wait for every owed result before the verdict
		wait_quiet();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("token_bucket_rate_limiter_core_test passed");
		else
			$display("token_bucket_rate_limiter_core_test failed");
		$finish;
	end

endmodule
`default_nettype wire
